### sv/gpb_pkg.sv
// shared types and constants for the gpio port bank
package gpb_pkg;

  typedef enum logic [2:0] {
    OpPinLevel  = 3'd0,
    OpWriteData = 3'd1,
    OpWriteDir  = 3'd2,
    OpWriteMode = 3'd3,
    OpReadData  = 3'd4
  } op_e;

  localparam logic EvPinChange = 1'b0;
  localparam logic EvReadData  = 1'b1;

  localparam logic [2:0] PortE = 3'd4;
  localparam logic [2:0] PortF = 3'd5;

  // index of the serial pin enable register in the register file
  localparam logic RegSerialEnables = 1'b0;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // work handed from the front to the back
  typedef struct packed {
    logic       kind;
    logic [2:0] port;
    logic [7:0] mask;
    logic [7:0] value;
  } job_t;

endpackage

### sv/gpb_front.sv
// front end: port registers, item decode and job generation
module gpb_front import gpb_pkg::*; #(
  parameter int PORT_COUNT       = 6,
  parameter int NARROW_PORT_PINS = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [2:0] operation_i,
  input  logic [2:0] port_index_i,
  input  logic [2:0] pin_number_i,
  input  logic       pin_level_i,
  input  logic [7:0] write_value_i,
  input  logic [3:0] serial_en_i,
  output logic       job_push_o,
  output job_t       job_o
);

  localparam logic [7:0] NarrowMask = 8'((1 << NARROW_PORT_PINS) - 1);
  localparam logic [3:0] NarrowPins = 4'(NARROW_PORT_PINS);

  logic [7:0] data_q [PORT_COUNT];
  logic [7:0] data_d [PORT_COUNT];
  logic [7:0] dir_q  [PORT_COUNT];
  logic [7:0] dir_d  [PORT_COUNT];
  logic [7:0] mode_q, mode_d;

  logic       port_ok;
  logic [7:0] sel_data, sel_dir, pmask, wval, diff, pin_m;
  op_e        op;

  assign op    = op_e'(operation_i);
  assign pin_m = 8'(1) << pin_number_i;
  assign pmask = (port_index_i == PortF) ? NarrowMask : 8'hFF;
  assign wval  = write_value_i & pmask;
  assign diff  = (sel_data ^ wval) & sel_dir;

  always_comb begin
    port_ok  = 1'b0;
    sel_data = '0;
    sel_dir  = '0;
    for (int i = 0; i < PORT_COUNT; i++) begin
      if (port_index_i == 3'(i)) begin
        port_ok  = 1'b1;
        sel_data = data_q[i];
        sel_dir  = dir_q[i];
      end
    end
  end

  always_comb begin
    logic take;
    take   = 1'b0;
    mode_d = mode_q;
    for (int i = 0; i < PORT_COUNT; i++) begin
      data_d[i] = data_q[i];
      dir_d[i]  = dir_q[i];
    end
    if (accept_i) begin
      unique case (op)
        OpPinLevel: begin
          for (int i = 0; i < PORT_COUNT; i++) begin
            if (port_index_i == 3'(i)) begin
              if (3'(i) == PortE) begin
                // low nibble of port e is owned by the serial units when enabled
                if (!pin_number_i[2]) begin
                  take = !serial_en_i[pin_number_i[1:0]];
                end else begin
                  take = ((dir_q[i] | mode_q) & pin_m) == '0;
                end
              end else if (3'(i) == PortF) begin
                take = ({1'b0, pin_number_i} < NarrowPins) && ((dir_q[i] & pin_m) == '0);
              end else begin
                take = (dir_q[i] & pin_m) == '0;
              end
              if (take) begin
                data_d[i] = pin_level_i ? (data_q[i] | pin_m) : (data_q[i] & ~pin_m);
              end
            end
          end
        end
        OpWriteData: begin
          for (int i = 0; i < PORT_COUNT; i++) begin
            if (port_index_i == 3'(i)) data_d[i] = wval;
          end
        end
        OpWriteDir: begin
          for (int i = 0; i < PORT_COUNT; i++) begin
            if (port_index_i == 3'(i)) dir_d[i] = wval;
          end
        end
        OpWriteMode: mode_d = write_value_i;
        OpReadData: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        data_q[i] <= '0;
        dir_q[i]  <= '0;
      end
      mode_q <= '0;
    end else begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        data_q[i] <= data_d[i];
        dir_q[i]  <= dir_d[i];
      end
      mode_q <= mode_d;
    end
  end

  always_comb begin
    job_push_o = 1'b0;
    job_o      = '0;
    job_o.port = port_index_i;
    if (accept_i && op == OpWriteData && port_ok && diff != '0) begin
      job_push_o  = 1'b1;
      job_o.kind  = EvPinChange;
      job_o.mask  = diff;
      job_o.value = wval;
    end else if (accept_i && op == OpReadData) begin
      // a read is one emission: single mask bit at pin zero
      job_push_o  = 1'b1;
      job_o.kind  = EvReadData;
      job_o.mask  = 8'h01;
      job_o.value = sel_data;
    end
  end

endmodule

### sv/gpb_queue.sv
// short job queue between the front and back ends
module gpb_queue import gpb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = cnt_q == (QueuePtrW+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push_i) - (QueuePtrW+1)'(pop_i);
    end
  end

endmodule

### sv/gpb_back.sv
// back end: expands jobs into result items, one per cycle while the output is popped or empty
module gpb_back import gpb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  job_t       q_job_i,
  output logic       q_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic       event_kind_o,
  output logic [2:0] out_port_o,
  output logic [2:0] out_pin_o,
  output logic       out_level_o,
  output logic [7:0] read_value_o,
  output logic       last_o
);

  logic       cur_valid_q;
  job_t       cur_q;
  logic       out_valid_q;
  logic       emit, fin, load;
  logic [7:0] low, rest;
  logic [2:0] idx;

  assign emit = cur_valid_q && (!out_valid_q || pop_i);
  assign low  = cur_q.mask & (~cur_q.mask + 8'd1);
  assign rest = cur_q.mask & ~low;
  assign fin  = rest == '0;
  assign load = !q_empty_i && (!cur_valid_q || (emit && fin));
  assign q_pop_o = load;
  assign empty_o = !out_valid_q;

  always_comb begin
    idx = '0;
    for (int b = 7; b >= 0; b--) begin
      if (low[b]) idx = 3'(b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
      end else if (emit && fin) begin
        cur_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_job_i;
    end else if (emit) begin
      cur_q.mask <= rest;
    end
    if (emit) begin
      event_kind_o <= cur_q.kind;
      out_port_o   <= cur_q.port;
      last_o       <= fin;
      if (cur_q.kind == EvReadData) begin
        out_pin_o    <= '0;
        out_level_o  <= 1'b0;
        read_value_o <= cur_q.value;
      end else begin
        out_pin_o    <= idx;
        out_level_o  <= |(cur_q.value & low);
        read_value_o <= '0;
      end
    end
  end

endmodule

### sv/gpio_port_bank_core.sv
// top level of the gpio port bank: register port, front, job queue and back
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | push / full          | operation, port_index, pin_number, pin_level,
//           |                      | write_value
//  result   | empty / pop          | event_kind, out_port, out_pin, out_level,
//           |                      | read_value, last
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready (always high)
//
// one item is accepted per cycle while the job queue has room; the front
// decodes and updates the port registers in the cycle of acceptance
// the back turns each job into results at one per cycle while the result side
// is popped or empty, so a data write changing k output pins gives k results, a read
// a single result; the first result passes the queue write at the accepting
// edge, then the job register, then the output register
// reset clears all port, direction, mode and enable registers at once
// a stalled result side fills the queue, then full is raised
module gpio_port_bank_core import gpb_pkg::*; #(
  parameter int PORT_COUNT       = 6,
  parameter int NARROW_PORT_PINS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input queue side
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation_i,
  input  logic [2:0]  port_index_i,
  input  logic [2:0]  pin_number_i,
  input  logic        pin_level_i,
  input  logic [7:0]  write_value_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic        event_kind_o,
  output logic [2:0]  out_port_o,
  output logic [2:0]  out_pin_o,
  output logic        out_level_o,
  output logic [7:0]  read_value_o,
  output logic        last_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       accept;
  logic       job_push, q_full, q_empty, q_pop;
  job_t       job_in, job_out;
  logic [3:0] serial_en_q;

  // serial pin enables: word index is paddr bit 2
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSerialEnables) ? {28'd0, serial_en_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_en_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == RegSerialEnables) begin
      serial_en_q <= pwdata[3:0];
    end
  end

  // the queue full flag holds off every item, even those that make no job
  assign full   = q_full;
  assign accept = push && !q_full;

  gpb_front #(
    .PORT_COUNT      (PORT_COUNT),
    .NARROW_PORT_PINS(NARROW_PORT_PINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .port_index_i (port_index_i),
    .pin_number_i (pin_number_i),
    .pin_level_i  (pin_level_i),
    .write_value_i(write_value_i),
    .serial_en_i  (serial_en_q),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  gpb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .job_o  (job_out)
  );

  gpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (job_out),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .event_kind_o(event_kind_o),
    .out_port_o  (out_port_o),
    .out_pin_o   (out_pin_o),
    .out_level_o (out_level_o),
    .read_value_o(read_value_o),
    .last_o      (last_o)
  );

endmodule
